// File: sv/tekp_pkg.sv
// ----------------------------------------------------------------------------
// tekp_pkg: shared types and codes for the tick encoder keypad scanner
// Request and response beat layouts, request codes and event codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tekp_pkg;

  // request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_DELAY = 2'd2;
  localparam logic [1:0] REQ_BEEP  = 2'd3;

  // event codes
  localparam logic [3:0] EV_NONE = 4'd0;
  localparam logic [3:0] EV_XUP  = 4'd1;
  localparam logic [3:0] EV_XDN  = 4'd2;
  localparam logic [3:0] EV_YUP  = 4'd3;
  localparam logic [3:0] EV_YDN  = 4'd4;
  localparam logic [3:0] EV_KEY1 = 4'd5;

  // encoder transitions {previous, current} that count as a step
  localparam logic [3:0] ENC_UP_A = 4'b0111;
  localparam logic [3:0] ENC_UP_B = 4'b1100;
  localparam logic [3:0] ENC_DN_A = 4'b0011;
  localparam logic [3:0] ENC_DN_B = 4'b0100;

  localparam int unsigned NUM_KEYS = 4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] raw_keys;
    logic [31:0] load_value;
  } req_t;

  typedef struct packed {
    logic [3:0]  event_code;
    logic        beep_off;
    logic        delay_busy;
    logic [31:0] tick_count;
  } rsp_t;

endpackage

`default_nettype wire

// File: sv/tekp_if.sv
// ----------------------------------------------------------------------------
// tekp_if: valid/ready channels of the scanner
// Request channel and response channel, each with source and sink sides.
// ----------------------------------------------------------------------------
`default_nettype none

interface tekp_req_if;
  logic          valid;
  logic          ready;
  tekp_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tekp_rsp_if;
  logic          valid;
  logic          ready;
  tekp_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: sv/tick_encoder_keypad_scanner.sv
// ----------------------------------------------------------------------------
// tick_encoder_keypad_scanner: tick-driven encoder and keypad scanner
// A request beat is held in the input register, and its response beat is registered in the response register.
// Throughput: one request per cycle; the input register and the response
// register stall together only when the response sink holds ready low.
// Reset clears counters, timers, input history and the latched event; the
// first tick after reset only samples encoders and keys.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_encoder_keypad_scanner (
  input  wire logic  clk,
  input  wire logic  rst,
  tekp_req_if.sink   req,
  tekp_rsp_if.source rsp
);

  logic           item_valid;
  tekp_pkg::req_t item;
  tekp_pkg::rsp_t result;
  logic           free;
  logic           fire;

  // held request moves on when the response register has room
  assign fire = item_valid && free;

  tekp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  tekp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  tekp_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .result (result),
    .free   (free),
    .rsp    (rsp)
  );

endmodule

`default_nettype wire

// File: sv/tekp_in_reg.sv
// ----------------------------------------------------------------------------
// tekp_in_reg: request input register
// Captures one request beat; frees itself when the core takes the beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tekp_in_reg (
  input  wire logic       clk,
  input  wire logic       rst,
  tekp_req_if.sink        req,
  input  wire logic       take,
  output logic            item_valid,
  output tekp_pkg::req_t  item
);

  // open when empty or when the held beat leaves this cycle
  assign req.ready = !item_valid || take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item <= req.payload;
    end
  end

endmodule

`default_nettype wire

// File: sv/tekp_core.sv
// ----------------------------------------------------------------------------
// tekp_core: scanner state and single-pass request logic
// Holds counters, timers, encoder/key history and the latched event, and
// forms the response for the request in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module tekp_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  wire tekp_pkg::req_t item,
  output tekp_pkg::rsp_t      result
);

  logic [31:0] tick_counter, tick_counter_next;
  logic [31:0] delay_left, delay_left_next;
  logic [31:0] beep_left, beep_left_next;
  logic [1:0]  enc_x_prev, enc_x_prev_next;
  logic [1:0]  enc_y_prev, enc_y_prev_next;
  logic [3:0]  keys_prev, keys_prev_next;
  logic        primed, primed_next;
  logic [3:0]  pending_event, pending_event_next;

  logic [15:0] keys_hi;
  logic [1:0]  enc_x, enc_y;
  logic [3:0]  keys;
  logic [3:0]  ev_x, ev_y, ev_key, ev_out;
  logic        beep_pulse;

  // encoder step decode: up, down or nothing
  function automatic logic [3:0] enc_event(input logic [1:0] prev, input logic [1:0] now,
                                           input logic [3:0] up, input logic [3:0] down);
    logic [3:0] idx;
    idx = {prev, now};
    if (idx == tekp_pkg::ENC_UP_A || idx == tekp_pkg::ENC_UP_B) begin
      return up;
    end else if (idx == tekp_pkg::ENC_DN_A || idx == tekp_pkg::ENC_DN_B) begin
      return down;
    end
    return tekp_pkg::EV_NONE;
  endfunction

  // highest pressed key, none when nothing pressed
  function automatic logic [3:0] key_event(input logic [3:0] k);
    logic [3:0] ev;
    ev = tekp_pkg::EV_NONE;
    for (int b = 0; b < tekp_pkg::NUM_KEYS; b++) begin
      if (k[b]) begin
        ev = tekp_pkg::EV_KEY1 + 4'(b);
      end
    end
    return ev;
  endfunction

  // active-high view of the raw bitmap
  assign keys_hi = ~item.raw_keys;
  assign enc_x   = keys_hi[13:12];
  assign enc_y   = keys_hi[15:14];
  assign keys    = keys_hi[3:0];

  assign ev_x   = enc_event(enc_x_prev, enc_x, tekp_pkg::EV_XUP, tekp_pkg::EV_XDN);
  assign ev_y   = enc_event(enc_y_prev, enc_y, tekp_pkg::EV_YUP, tekp_pkg::EV_YDN);
  assign ev_key = (keys != keys_prev) ? key_event(keys) : tekp_pkg::EV_NONE;

  // next state and response for the current request
  always_comb begin
    tick_counter_next  = tick_counter;
    delay_left_next    = delay_left;
    beep_left_next     = beep_left;
    enc_x_prev_next    = enc_x_prev;
    enc_y_prev_next    = enc_y_prev;
    keys_prev_next     = keys_prev;
    primed_next        = primed;
    pending_event_next = pending_event;
    ev_out             = tekp_pkg::EV_NONE;
    beep_pulse         = 1'b0;
    case (item.req_type)
      tekp_pkg::REQ_TICK: begin
        tick_counter_next = tick_counter + 32'd1;
        if (delay_left != 32'd0) begin
          delay_left_next = delay_left - 32'd1;
        end
        if (beep_left != 32'd0) begin
          beep_left_next = beep_left - 32'd1;
          beep_pulse     = (beep_left == 32'd1);
        end
        enc_x_prev_next = enc_x;
        enc_y_prev_next = enc_y;
        keys_prev_next  = keys;
        primed_next     = 1'b1;
        // later checks override earlier ones
        if (primed) begin
          if (ev_x != tekp_pkg::EV_NONE) pending_event_next = ev_x;
          if (ev_y != tekp_pkg::EV_NONE) pending_event_next = ev_y;
          if (ev_key != tekp_pkg::EV_NONE) pending_event_next = ev_key;
        end
      end
      tekp_pkg::REQ_READ: begin
        ev_out             = pending_event;
        pending_event_next = tekp_pkg::EV_NONE;
      end
      tekp_pkg::REQ_DELAY: begin
        delay_left_next = item.load_value;
      end
      tekp_pkg::REQ_BEEP: begin
        beep_left_next = item.load_value;
      end
      default: begin
      end
    endcase
  end

  assign result.event_code = ev_out;
  assign result.beep_off   = beep_pulse;
  assign result.delay_busy = (delay_left_next != 32'd0);
  assign result.tick_count = tick_counter_next;

  // state update on each processed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter  <= '0;
      delay_left    <= '0;
      beep_left     <= '0;
      enc_x_prev    <= '0;
      enc_y_prev    <= '0;
      keys_prev     <= '0;
      primed        <= 1'b0;
      pending_event <= tekp_pkg::EV_NONE;
    end else if (fire) begin
      tick_counter  <= tick_counter_next;
      delay_left    <= delay_left_next;
      beep_left     <= beep_left_next;
      enc_x_prev    <= enc_x_prev_next;
      enc_y_prev    <= enc_y_prev_next;
      keys_prev     <= keys_prev_next;
      primed        <= primed_next;
      pending_event <= pending_event_next;
    end
  end

  // read clears the latched event
  a_read_clears: assert property (@(posedge clk) disable iff (rst)
    fire && item.req_type == tekp_pkg::REQ_READ |=> pending_event == tekp_pkg::EV_NONE)
    else $error("latched event not cleared by read");

  // no event can be latched before the first tick
  a_no_event_unprimed: assert property (@(posedge clk) disable iff (rst)
    !primed |-> pending_event == tekp_pkg::EV_NONE)
    else $error("event latched before first sample");

  // counter moves only on ticks
  a_counter_on_tick: assert property (@(posedge clk) disable iff (rst)
    fire && item.req_type != tekp_pkg::REQ_TICK |=> $stable(tick_counter))
    else $error("tick counter moved on a non-tick beat");

  // beep pulse leaves the beep timer at zero
  a_beep_done: assert property (@(posedge clk) disable iff (rst)
    fire && result.beep_off |=> beep_left == 32'd0)
    else $error("beep timer not empty after beep_off");

endmodule

`default_nettype wire

// File: sv/tekp_out_reg.sv
// ----------------------------------------------------------------------------
// tekp_out_reg: response output register
// Holds one response beat until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tekp_out_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  wire tekp_pkg::rsp_t result,
  output logic                free,
  tekp_rsp_if.source          rsp
);

  // room for a new beat when empty or draining this cycle
  assign free = !rsp.valid || rsp.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (free) begin
      rsp.valid <= fire;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.payload <= result;
    end
  end

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for tick_encoder_keypad_scanner
// Sends request beats with random gaps and keeps its own model of the tick
// counter, timers, encoder history, key history and latched event. Each
// accepted request is turned into an expected response, and every response
// beat is compared field by field, in order, against the oldest one waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int unsigned STUCK_LIMIT = 1000;
  localparam int unsigned SINK_HOLD   = 200;
  localparam int unsigned DRAIN_WAIT  = 10;

  logic clk;
  logic rst;

  tekp_req_if req_ch ();
  tekp_rsp_if rsp_ch ();

  tick_encoder_keypad_scanner u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shared controls between stimulus, sink and checker
  bit             gaps_on = 1'b1;
  int unsigned    sink_hold_cycles = 0;
  int unsigned    fail_count = 0;
  int unsigned    rsp_beats = 0;
  int unsigned    stuck_cycles = 0;
  tekp_pkg::rsp_t scan_rsp_q[$];

  // scanner model state
  logic [31:0] scan_ticks = '0;
  logic [31:0] scan_delay_left = '0;
  logic [31:0] scan_beep_left = '0;
  logic [1:0]  enc_x_last = '0;
  logic [1:0]  enc_y_last = '0;
  logic [3:0]  keys_last = '0;
  bit          scan_primed = 1'b0;
  logic [3:0]  latched_event = tekp_pkg::EV_NONE;

  // stimulus generator state, in pressed (active-high) terms
  logic [1:0]  gen_x = 2'b11;
  logic [1:0]  gen_y = 2'b11;
  logic [3:0]  gen_keys = 4'h0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic tekp_pkg::req_t tick_beat(logic [1:0] ey, logic [1:0] ex,
                                               logic [3:0] keys);
    tekp_pkg::req_t b;
    b.req_type   = tekp_pkg::REQ_TICK;
    b.raw_keys   = ~{ey, ex, 8'($urandom), keys};
    b.load_value = $urandom;
    return b;
  endfunction

  function automatic tekp_pkg::req_t ctrl_beat(logic [1:0] kind, logic [31:0] value);
    tekp_pkg::req_t b;
    b.req_type   = kind;
    b.raw_keys   = 16'($urandom);
    b.load_value = value;
    return b;
  endfunction

  // encoder transition: returns the event that stands after this check
  function automatic logic [3:0] enc_event(logic [1:0] last, logic [1:0] now,
                                           logic [3:0] up, logic [3:0] dn,
                                           logic [3:0] cur);
    case ({last, now})
      tekp_pkg::ENC_UP_A, tekp_pkg::ENC_UP_B: return up;
      tekp_pkg::ENC_DN_A, tekp_pkg::ENC_DN_B: return dn;
      default:                                return cur;
    endcase
  endfunction

  // update the model with one accepted request and queue its response
  task automatic predict_scan(input tekp_pkg::req_t item);
    tekp_pkg::rsp_t want;
    logic [15:0]    pressed;
    want    = '0;
    pressed = ~item.raw_keys;
    case (item.req_type)
      tekp_pkg::REQ_TICK: begin
        scan_ticks = scan_ticks + 1;
        if (scan_delay_left != 0) scan_delay_left = scan_delay_left - 1;
        if (scan_beep_left != 0) begin
          scan_beep_left = scan_beep_left - 1;
          if (scan_beep_left == 0) want.beep_off = 1'b1;
        end
        if (!scan_primed) begin
          enc_x_last  = pressed[13:12];
          enc_y_last  = pressed[15:14];
          keys_last   = pressed[3:0];
          scan_primed = 1'b1;
        end else begin
          latched_event = enc_event(enc_x_last, pressed[13:12], tekp_pkg::EV_XUP,
                                    tekp_pkg::EV_XDN, latched_event);
          enc_x_last    = pressed[13:12];
          latched_event = enc_event(enc_y_last, pressed[15:14], tekp_pkg::EV_YUP,
                                    tekp_pkg::EV_YDN, latched_event);
          enc_y_last    = pressed[15:14];
          // highest pressed key wins; release of all keys raises nothing
          if (keys_last != pressed[3:0]) begin
            for (int b = 0; b < tekp_pkg::NUM_KEYS; b++)
              if (pressed[b]) latched_event = 4'(tekp_pkg::EV_KEY1 + b);
            keys_last = pressed[3:0];
          end
        end
      end
      tekp_pkg::REQ_READ: begin
        want.event_code = latched_event;
        latched_event   = tekp_pkg::EV_NONE;
      end
      tekp_pkg::REQ_DELAY: scan_delay_left = item.load_value;
      default:             scan_beep_left = item.load_value;
    endcase
    want.delay_busy = (scan_delay_left != 0);
    want.tick_count = scan_ticks;
    scan_rsp_q.push_back(want);
  endtask

  function automatic void report_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // present one request beat and wait until it is taken
  task automatic send_req(input tekp_pkg::req_t item);
    int unsigned gap;
    req_ch.valid   <= 1'b1;
    req_ch.payload <= item;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // encoder walk: mostly table steps or no move, some random jumps
  function automatic logic [1:0] next_enc(logic [1:0] cur);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      case (cur)
        2'b01:   return $urandom_range(0, 1) ? 2'b11 : 2'b00;
        2'b11:   return 2'b00;
        2'b00:   return 2'b11;
        default: return 2'($urandom);
      endcase
    end
    if (r < 7) return cur;
    return 2'($urandom);
  endfunction

  function automatic tekp_pkg::req_t random_req();
    int unsigned r;
    logic [31:0] value;
    r = $urandom_range(0, 99);
    value = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'($urandom_range(0, 20));
    if (r < 55) begin
      gen_x = next_enc(gen_x);
      gen_y = next_enc(gen_y);
      if ($urandom_range(0, 9) >= 6) gen_keys = 4'($urandom);
      return tick_beat(gen_y, gen_x, gen_keys);
    end
    if (r < 80) return ctrl_beat(tekp_pkg::REQ_READ, 32'($urandom));
    if (r < 90) return ctrl_beat(tekp_pkg::REQ_DELAY, value);
    return ctrl_beat(tekp_pkg::REQ_BEEP, value);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // read before any tick, then a first tick that only samples
  task automatic test_first_tick();
    send_req(ctrl_beat(tekp_pkg::REQ_READ, 32'hFFFF_FFFF));
    send_req(tick_beat(2'b11, 2'b11, 4'hF));
    send_req(ctrl_beat(tekp_pkg::REQ_READ, 32'h0));
  endtask

  // table steps up and down, no-step moves, later check overriding earlier
  task automatic test_encoders();
    send_req(tick_beat(2'b11, 2'b00, 4'hF));
    send_req(ctrl_beat(tekp_pkg::REQ_READ, 32'h0));
    send_req(tick_beat(2'b11, 2'b11, 4'hF));
    send_req(tick_beat(2'b00, 2'b11, 4'hF));
    send_req(ctrl_beat(tekp_pkg::REQ_READ, 32'h0));
    send_req(tick_beat(2'b01, 2'b01, 4'hF));
    send_req(tick_beat(2'b00, 2'b11, 4'hF));
    send_req(ctrl_beat(tekp_pkg::REQ_READ, 32'h0));
  endtask

  // release of all keys, single key, highest key, key over encoder
  task automatic test_keys();
    send_req(tick_beat(2'b10, 2'b00, 4'h0));
    send_req(ctrl_beat(tekp_pkg::REQ_READ, 32'h0));
    send_req(tick_beat(2'b10, 2'b00, 4'h1));
    send_req(tick_beat(2'b10, 2'b00, 4'h9));
    send_req(ctrl_beat(tekp_pkg::REQ_READ, 32'h0));
    send_req(tick_beat(2'b10, 2'b11, 4'h6));
    send_req(ctrl_beat(tekp_pkg::REQ_READ, 32'h0));
  endtask

  // delay busy flag, beep pulse at one, zero load with no pulse
  task automatic test_timers();
    send_req(ctrl_beat(tekp_pkg::REQ_DELAY, 32'hFFFF_FFFF));
    send_req(ctrl_beat(tekp_pkg::REQ_DELAY, 32'h2));
    send_req(ctrl_beat(tekp_pkg::REQ_BEEP, 32'h1));
    send_req(tick_beat(2'b10, 2'b11, 4'h6));
    send_req(tick_beat(2'b10, 2'b11, 4'h6));
    send_req(ctrl_beat(tekp_pkg::REQ_BEEP, 32'h0));
    send_req(tick_beat(2'b10, 2'b11, 4'h6));
    send_req(ctrl_beat(tekp_pkg::REQ_BEEP, 32'hFFFF_FFFF));
    send_req(ctrl_beat(tekp_pkg::REQ_DELAY, 32'h0));
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) send_req(random_req());
  endtask

  task automatic test_back_to_back(input int unsigned count);
    gaps_on = 1'b0;
    repeat (count) send_req(random_req());
    gaps_on = 1'b1;
  endtask

  // sink holds ready low for a long stretch while beats keep coming
  task automatic test_sink_hold(input int unsigned count);
    gaps_on = 1'b0;
    sink_hold_cycles = SINK_HOLD;
    repeat (count) send_req(random_req());
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // response sink: random stalls, or a long hold when asked
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_cycles != 0) begin
        rsp_ch.ready <= 1'b0;
        n = sink_hold_cycles;
        repeat (n) @(posedge clk);
        sink_hold_cycles = 0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        n = pick_gap();
        repeat (n) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // model update on each accepted request beat
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) predict_scan(req_ch.payload);
  end

  // in-order compare of response beats
  always @(posedge clk) begin
    tekp_pkg::rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      rsp_beats++;
      if (scan_rsp_q.size() == 0) begin
        report_failure($sformatf("beat %0d: response with none expected", rsp_beats));
      end else begin
        want = scan_rsp_q.pop_front();
        if (rsp_ch.payload.event_code !== want.event_code ||
            rsp_ch.payload.beep_off   !== want.beep_off   ||
            rsp_ch.payload.delay_busy !== want.delay_busy ||
            rsp_ch.payload.tick_count !== want.tick_count)
          report_failure($sformatf(
            {"beat %0d: expected ev=%0d beep=%0b busy=%0b ticks=%0d, ",
             "got ev=%0d beep=%0b busy=%0b ticks=%0d"},
            rsp_beats, want.event_code, want.beep_off, want.delay_busy, want.tick_count,
            rsp_ch.payload.event_code, rsp_ch.payload.beep_off,
            rsp_ch.payload.delay_busy, rsp_ch.payload.tick_count));
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst            <= 1'b1;
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_first_tick();
    test_encoders();
    test_keys();
    test_timers();
    test_random_traffic(400);
    test_sink_hold(40);
    test_back_to_back(120);
    test_random_traffic(240);

    req_ch.valid <= 1'b0;
    while (scan_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0 && scan_rsp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: tick_encoder_keypad_scanner.f
sv/tekp_pkg.sv
sv/tekp_if.sv
sv/tekp_in_reg.sv
sv/tekp_core.sv
sv/tekp_out_reg.sv
sv/tick_encoder_keypad_scanner.sv
tb/tb_top.sv
